[sv/ms_delay_event_timer_assert.svh]
// assertion macros for the delay event timer checker
// used by mdet_checker.sv, expects clk and rst_n in scope
`ifndef MS_DELAY_EVENT_TIMER_ASSERT_SVH
`define MS_DELAY_EVENT_TIMER_ASSERT_SVH

// checked only outside reset
`define MDET_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mdet assertion failed");

// checked during reset as well
`define MDET_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("mdet reset assertion failed");

`endif

[sv/mdet_pkg.sv]
// shared types and codes for the delay event timer
// no dependencies
`timescale 1ns / 1ps

package mdet_pkg;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_ARM   = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_STOP  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [1:0] CFG_COMPARE_MODE = 2'd0;
  localparam logic [1:0] CFG_TICKS_PER_MS = 2'd1;
  localparam logic [1:0] CFG_COMPARE_TOP  = 2'd2;

  localparam logic [15:0] TICKS_PER_MS_RST = 16'd125;
  localparam logic [7:0]  COMPARE_TOP_RST  = 8'd249;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ARM,
    OP_START,
    OP_STOP,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef enum logic [0:0] {
    BK_EXEC,
    BK_DIV
  } back_state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] delay_ms;
    logic        single_shot;
  } in_word_t;

  typedef struct packed {
    logic [7:0] counter_value;
    logic       fire;
    logic       armed;
    logic       running;
  } out_word_t;

  typedef struct packed {
    logic        compare_mode;
    logic [15:0] ticks_per_ms;
    logic [7:0]  compare_top;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] ticks;
    logic        single;
  } q_entry_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [16:0] rem;
  } div_rsp_t;

endpackage

[sv/mdet_front.sv]
// front end: takes input words, scales the delay to ticks and decodes the command
// depends on mdet_pkg
`timescale 1ns / 1ps

module mdet_front
  import mdet_pkg::*;
(
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     q_push,
  output q_entry_t q_push_data
);

  logic [31:0] ticks;
  op_t         op;

  assign ticks = 32'(in_data.delay_ms) * 32'(cfg.ticks_per_ms);

  always_comb begin
    unique case (in_data.command)
      CMD_TICK:  op = OP_TICK;
      CMD_ARM:   op = (ticks == 32'd0) ? OP_READ : OP_ARM;
      CMD_START: op = OP_START;
      CMD_STOP:  op = OP_STOP;
      CMD_CLEAR: op = OP_CLEAR;
      default:   op = OP_READ;
    endcase
  end

  assign in_ready           = !q_full;
  assign q_push             = in_valid && !q_full;
  assign q_push_data.op     = op;
  assign q_push_data.ticks  = ticks;
  assign q_push_data.single = in_data.single_shot;

endmodule

[sv/mdet_fifo.sv]
// two-entry queue between the front end and the execution back end
// depends on mdet_pkg
`timescale 1ns / 1ps

module mdet_fifo
  import mdet_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t   mem_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/mdet_div.sv]
// radix-2 restoring divider, 32-bit dividend by 17-bit divisor, one bit a cycle
// depends on mdet_pkg
`timescale 1ns / 1ps

module mdet_div
  import mdet_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] dvs_r, dvs_nxt;
  logic [17:0] trial;
  logic [17:0] diff;

  assign trial = {rem_r, quo_r[31]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      quo_nxt  = req.dividend;
      rem_nxt  = 17'd0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[30:0], !diff[17]};
      rem_nxt = diff[17] ? trial[16:0] : diff[16:0];
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

[sv/mdet_back.sv]
// back end: timer state, tick and command execution, arm setup, output register
// depends on mdet_pkg and mdet_div
`timescale 1ns / 1ps

module mdet_back
  import mdet_pkg::*;
#(
  parameter int COUNTER_MODULUS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      head_valid,
  input  q_entry_t  head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int CW = $clog2(COUNTER_MODULUS);
  localparam int MW = (CW > 8) ? CW : 8;

  back_state_t state_r, state_nxt;

  logic [CW-1:0] hw_r, hw_nxt;
  logic          running_r, running_nxt;
  logic          armed_r, armed_nxt;
  logic          once_r, once_nxt;
  logic [31:0]   ecount_r, ecount_nxt;
  logic [31:0]   target_r, target_nxt;
  logic [CW-1:0] restart_r, restart_nxt;
  logic [7:0]    match_r, match_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic          slot_free;
  logic          is_arm;
  logic          exec_go;
  logic          arm_go;
  logic          arm_done;
  logic          fire;
  logic [CW:0]   cnt_inc;
  logic          wrap;
  logic [CW-1:0] cnt_wrapped;
  logic [CW-1:0] tick_cnt;
  logic          tick_event;
  logic [31:0]   ecount_inc;
  logic          hit;
  logic [8:0]    span;
  logic [CW:0]   restart_calc;
  logic [MW-1:0] hw_view;

  mdet_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign is_arm    = head.op == OP_ARM;
  assign span      = {1'b0, cfg.compare_top} + 9'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_EXEC: begin
        if (head_valid && slot_free && is_arm) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          state_nxt = BK_EXEC;
        end
      end
      default: state_nxt = BK_EXEC;
    endcase
  end

  // state outputs
  always_comb begin
    exec_go  = 1'b0;
    arm_go   = 1'b0;
    arm_done = 1'b0;
    unique case (state_r)
      BK_EXEC: begin
        exec_go = head_valid && slot_free && !is_arm;
        arm_go  = head_valid && slot_free && is_arm;
      end
      BK_DIV: begin
        arm_done = div_rsp.done;
      end
      default: ;
    endcase
  end

  assign pop = exec_go || arm_done;

  assign div_req.start    = arm_go;
  assign div_req.dividend = head.ticks;
  assign div_req.divisor  = cfg.compare_mode ? 17'(span) : 17'(COUNTER_MODULUS);

  // tick datapath
  always_comb begin
    cnt_inc     = {1'b0, hw_r} + (CW+1)'(1);
    wrap        = cnt_inc == (CW+1)'(COUNTER_MODULUS);
    cnt_wrapped = wrap ? '0 : cnt_inc[CW-1:0];
    if (cfg.compare_mode) begin
      tick_event = MW'(hw_r) == MW'(match_r);
      tick_cnt   = tick_event ? '0 : cnt_wrapped;
    end else begin
      tick_event = wrap;
      tick_cnt   = cnt_wrapped;
    end
    ecount_inc   = ecount_r + 32'd1;
    hit          = ecount_inc == target_r;
    restart_calc = (CW+1)'(COUNTER_MODULUS) - div_rsp.rem[CW:0];
  end

  always_comb begin
    hw_nxt      = hw_r;
    running_nxt = running_r;
    armed_nxt   = armed_r;
    once_nxt    = once_r;
    ecount_nxt  = ecount_r;
    target_nxt  = target_r;
    restart_nxt = restart_r;
    match_nxt   = match_r;
    fire        = 1'b0;
    if (exec_go) begin
      case (head.op)
        OP_TICK: begin
          if (running_r) begin
            hw_nxt = tick_cnt;
            if (tick_event && armed_r) begin
              if (hit) begin
                ecount_nxt = 32'd0;
                fire       = 1'b1;
                if (once_r) begin
                  armed_nxt = 1'b0;
                end else if (!cfg.compare_mode) begin
                  hw_nxt = restart_r;
                end
              end else begin
                ecount_nxt = ecount_inc;
              end
            end
          end
        end
        OP_START: running_nxt = 1'b1;
        OP_STOP:  running_nxt = 1'b0;
        OP_CLEAR: begin
          hw_nxt      = '0;
          running_nxt = 1'b1;
        end
        default: ;
      endcase
    end else if (arm_done) begin
      if (!cfg.compare_mode) begin
        if (div_rsp.rem == 17'd0) begin
          restart_nxt = '0;
          target_nxt  = div_rsp.quo;
        end else begin
          restart_nxt = restart_calc[CW-1:0];
          target_nxt  = div_rsp.quo + 32'd1;
        end
        hw_nxt = restart_nxt;
      end else begin
        if (head.ticks <= 32'(span)) begin
          match_nxt  = head.ticks[7:0] - 8'd1;
          target_nxt = 32'd1;
        end else begin
          match_nxt  = cfg.compare_top;
          target_nxt = div_rsp.quo;
        end
        restart_nxt = '0;
      end
      ecount_nxt = 32'd0;
      once_nxt   = head.single;
      armed_nxt  = 1'b1;
    end
  end

  // output word
  always_comb begin
    hw_view                    = MW'(hw_nxt);
    out_data_nxt.counter_value = hw_view[7:0];
    out_data_nxt.fire          = fire;
    out_data_nxt.armed         = armed_nxt;
    out_data_nxt.running       = running_nxt;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_EXEC;
      hw_r        <= '0;
      running_r   <= 1'b0;
      armed_r     <= 1'b0;
      once_r      <= 1'b0;
      ecount_r    <= 32'd0;
      target_r    <= 32'd0;
      restart_r   <= '0;
      match_r     <= 8'hFF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      running_r   <= running_nxt;
      armed_r     <= armed_nxt;
      once_r      <= once_nxt;
      ecount_r    <= ecount_nxt;
      target_r    <= target_nxt;
      restart_r   <= restart_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/ms_delay_event_timer.sv]
// top level of the millisecond delay event timer: config registers, front, queue, back
// depends on mdet_pkg, mdet_front, mdet_fifo, mdet_back
//
//   port group   direction   handshake            word
//   in_*         input       in_valid/in_ready    in_word_t
//   out_*        output      out_valid/out_ready  out_word_t
//   cfg_*        input       cfg_we               cfg_index, cfg_wdata
//
// tick, start, stop and clear words and read words are executed straight from the queue head in the back end
// an arm word holds the back end in the divide state until the one-bit-a-cycle divider is done
// a two-word queue lets the front accept one more word while an arm is in the divider
// the output register takes a new word in the cycle the old one is taken
// synchronous active-low reset; no clearing pass
`timescale 1ns / 1ps

module ms_delay_event_timer
  import mdet_pkg::*;
#(
  parameter int COUNTER_MODULUS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t     cfg_r, cfg_nxt;
  logic     q_full;
  logic     q_push;
  q_entry_t q_push_data;
  logic     q_pop;
  logic     q_head_valid;
  q_entry_t q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMPARE_MODE: cfg_nxt.compare_mode = cfg_wdata[0];
        CFG_TICKS_PER_MS: cfg_nxt.ticks_per_ms = cfg_wdata;
        CFG_COMPARE_TOP:  cfg_nxt.compare_top  = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.compare_mode <= 1'b0;
      cfg_r.ticks_per_ms <= TICKS_PER_MS_RST;
      cfg_r.compare_top  <= COMPARE_TOP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mdet_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg         (cfg_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  mdet_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  mdet_back #(
    .COUNTER_MODULUS (COUNTER_MODULUS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[sv/mdet_checker.sv]
// port-level checker for the delay event timer, bound to the top level
// depends on mdet_pkg and ms_delay_event_timer_assert.svh
`timescale 1ns / 1ps

`include "ms_delay_event_timer_assert.svh"

module mdet_checker
  import mdet_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  logic [2:0] inflight_r, inflight_nxt;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r + 3'(in_take) - 3'(out_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 3'd0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // no result word right after reset
  `MDET_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid)
  // a stalled result word stays offered
  `MDET_ASSERT(a_out_holds, out_valid && !out_ready |=> out_valid)
  // every result word belongs to an accepted input word
  `MDET_ASSERT(a_no_extra_word, out_valid |-> inflight_r != 3'd0)
  // a fire only comes from a tick that advanced a running counter
  `MDET_ASSERT(a_fire_running, out_valid && out_data.fire |-> out_data.running)

endmodule

bind ms_delay_event_timer mdet_checker u_mdet_checker (.*);

[sim/mdet_timer_check.sv]
// checker for the delay event timer: a cycle-free model of the timer plus result compare
// watches the in, out and cfg ports of ms_delay_event_timer; depends on mdet_pkg
`timescale 1ns / 1ps

module mdet_timer_check
  import mdet_pkg::*;
#(
  parameter int MODULUS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen,
  output int          fires_seen
);

  logic        mode_r;
  logic [15:0] tpm_r;
  logic [7:0]  top_r;

  int unsigned hw_cnt;
  int unsigned evt_cnt;
  int unsigned evt_tgt;
  int unsigned reload_v;
  int unsigned match_v;
  bit          run_f;
  bit          arm_f;
  bit          once_f;

  out_word_t predicted_words[$];
  int        errs = 0;
  int        seen = 0;
  int        fires = 0;
  int        pend_r = 0;

  assign mismatches   = errs;
  assign outstanding  = pend_r;
  assign results_seen = seen;
  assign fires_seen   = fires;

  function automatic out_word_t timer_step(input in_word_t w);
    out_word_t   r;
    int unsigned ticks;
    int unsigned span;
    bit          hit;
    bit          fired;
    ticks = 32'(w.delay_ms) * 32'(tpm_r);
    hit = 1'b0;
    fired = 1'b0;
    case (w.command)
      OP_TICK: begin
        if (run_f) begin
          if (mode_r) begin
            if (hw_cnt == match_v) begin
              hw_cnt = 0;
              hit = 1'b1;
            end else begin
              hw_cnt = (hw_cnt + 1) % MODULUS;
            end
          end else begin
            hw_cnt = hw_cnt + 1;
            if (hw_cnt >= MODULUS) begin
              hw_cnt = 0;
              hit = 1'b1;
            end
          end
          if (hit && arm_f) begin
            evt_cnt = evt_cnt + 1;
            if (evt_cnt == evt_tgt) begin
              evt_cnt = 0;
              fired = 1'b1;
              if (once_f) arm_f = 1'b0;
              else if (!mode_r) hw_cnt = reload_v;
            end
          end
        end
      end
      OP_ARM: begin
        // zero tick count leaves everything as it was
        if (ticks != 0) begin
          if (!mode_r) begin
            if (ticks % MODULUS == 0) begin
              reload_v = 0;
              evt_tgt = ticks / MODULUS;
            end else begin
              reload_v = MODULUS - ticks % MODULUS;
              evt_tgt = ticks / MODULUS + 1;
            end
            hw_cnt = reload_v;
          end else begin
            span = 32'(top_r) + 1;
            if (ticks <= span) begin
              match_v = ticks - 1;
              evt_tgt = 1;
            end else begin
              match_v = 32'(top_r);
              evt_tgt = ticks / span;
            end
            reload_v = 0;
          end
          evt_cnt = 0;
          once_f = w.single_shot;
          arm_f = 1'b1;
        end
      end
      OP_START: run_f = 1'b1;
      OP_STOP:  run_f = 1'b0;
      OP_CLEAR: begin
        hw_cnt = 0;
        run_f = 1'b1;
      end
      default: ;
    endcase
    r.counter_value = 8'(hw_cnt);
    r.fire = fired;
    r.armed = arm_f;
    r.running = run_f;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      mode_r = 1'b0;
      tpm_r = TICKS_PER_MS_RST;
      top_r = COMPARE_TOP_RST;
      hw_cnt = 0;
      run_f = 1'b0;
      arm_f = 1'b0;
      once_f = 1'b0;
      evt_cnt = 0;
      evt_tgt = 0;
      reload_v = 0;
      match_v = 8'hff;
      predicted_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COMPARE_MODE: mode_r = cfg_wdata[0];
          CFG_TICKS_PER_MS: tpm_r = cfg_wdata;
          CFG_COMPARE_TOP:  top_r = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen++;
        if (predicted_words.size() == 0) begin
          if (errs < 10)
            $display("result %0d arrived with nothing predicted: %h", seen, out_data);
          errs++;
        end else begin
          want = predicted_words.pop_front();
          if (want.fire) fires++;
          if (out_data.counter_value !== want.counter_value ||
              out_data.fire !== want.fire ||
              out_data.armed !== want.armed ||
              out_data.running !== want.running) begin
            if (errs < 10)
              $display("result %0d: want count %0d fire %0b armed %0b running %0b, %s %0d %0b %0b %0b",
                       seen, want.counter_value, want.fire, want.armed, want.running, "got",
                       out_data.counter_value, out_data.fire, out_data.armed,
                       out_data.running);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) predicted_words.push_back(timer_step(in_data));
    end
    pend_r <= predicted_words.size();
  end

endmodule

[sim/ms_delay_event_timer_test.sv]
// top of the delay event timer test: clock, reset, directed and random words, verdict
// depends on mdet_pkg, ms_delay_event_timer and mdet_timer_check
`timescale 1ns / 1ps

module ms_delay_event_timer_test;
  import mdet_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_WORDS   = 205;
  localparam int NUM_PHASES    = 8;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_COMPARE_MODE;
  logic [15:0] cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int results_seen;
  int fires_seen;

  int send_pct = 0;
  int recv_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;
  int words_sent = 0;

  ms_delay_event_timer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mdet_timer_check i_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .fires_seen   (fires_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic in_word_t make_word(input logic [2:0] cmd, input logic [15:0] ms,
                                         input logic single);
    in_word_t w;
    w.command = cmd;
    w.delay_ms = ms;
    w.single_shot = single;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    pick = $urandom_range(99);
    w.command = OP_TICK;
    w.delay_ms = 16'($urandom());
    w.single_shot = 1'($urandom_range(1));
    if (pick < 62) begin
      w.command = OP_TICK;
    end else if (pick < 70) begin
      w.command = OP_ARM;
      pick = $urandom_range(99);
      if (pick < 70) w.delay_ms = 16'($urandom_range(4, 1));
      else if (pick < 80) w.delay_ms = 16'($urandom_range(40, 5));
      else if (pick < 94) w.delay_ms = 16'($urandom());
      else if (pick < 97) w.delay_ms = 16'd0;
      else w.delay_ms = 16'hffff;
    end else if (pick < 76) begin
      w.command = OP_START;
    end else if (pick < 80) begin
      w.command = OP_STOP;
    end else if (pick < 85) begin
      w.command = OP_CLEAR;
    end else if (pick < 90) begin
      w.command = OP_READ;
    end else if (pick < 95) begin
      w.command = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
    end else begin
      w.command = 3'($urandom());
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic mode, input logic [15:0] tpm, input logic [7:0] top);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= CFG_COMPARE_MODE;
    cfg_wdata <= 16'(mode);
    @(posedge clk);
    cfg_index <= CFG_TICKS_PER_MS;
    cfg_wdata <= tpm;
    @(posedge clk);
    cfg_index <= CFG_COMPARE_TOP;
    cfg_wdata <= 16'(top);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: stopped tick, zero delay, longest delay, spare commands
    send_word(make_word(OP_READ, 16'd0, 1'b0));
    send_word(make_word(OP_TICK, 16'hffff, 1'b1));
    send_word(make_word(OP_ARM, 16'd0, 1'b1));
    send_word(make_word(OP_ARM, 16'hffff, 1'b1));
    send_word(make_word(OP_START, 16'd0, 1'b0));
    send_word(make_word(OP_TICK, 16'd0, 1'b0));
    send_word(make_word(OP_CLEAR, 16'd0, 1'b0));
    send_word(make_word(OP_STOP, 16'd0, 1'b0));
    send_word(make_word(OP_TICK, 16'd0, 1'b0));
    send_word(make_word(CMD_SPARE_6, 16'hffff, 1'b1));
    send_word(make_word(CMD_SPARE_7, 16'h5a5a, 1'b0));

    // one tick per ms: single shot, idle counting, periodic reload, zero remainder
    write_regs(1'b0, 16'd1, 8'd249);
    send_word(make_word(OP_ARM, 16'd3, 1'b1));
    send_word(make_word(OP_START, 16'd0, 1'b0));
    repeat (4) send_word(make_word(OP_TICK, 16'd0, 1'b0));
    send_word(make_word(OP_ARM, 16'd2, 1'b0));
    repeat (4) send_word(make_word(OP_TICK, 16'd0, 1'b0));
    send_word(make_word(OP_ARM, 16'd256, 1'b0));
    send_word(make_word(OP_READ, 16'd0, 1'b0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: write_regs(1'b0, 16'd1, 8'd249);
        1: write_regs(1'b1, 16'd1, 8'd7);
        2: write_regs(1'b0, 16'd3, 8'd255);
        3: write_regs(1'b1, 16'd2, 8'd0);
        4: write_regs(1'b1, 16'hffff, 8'd255);
        5: write_regs(1'b0, 16'd0, 8'd1);
        6: write_regs(1'b1, 16'd1, 8'd1);
        default: write_regs(1'b0, 16'd2, 8'd100);
      endcase
      case (p % 4)
        0: begin
          send_pct <= 0;
          recv_pct <= 0;
        end
        1: begin
          send_pct <= 61;
          recv_pct <= 0;
        end
        2: begin
          send_pct <= 0;
          recv_pct <= 61;
        end
        default: begin
          send_pct <= 19;
          recv_pct <= 19;
        end
      endcase
      // fill the block up behind a long receiver hold-off
      if (p == 2) hold_req <= hold_req + 1;
      for (int k = 0; k < PHASE_WORDS; k++) send_word(random_word());
    end

    wait_drained();
    $display("%0d words over %0d register settings, both counting modes, ticks_per_ms 0..65535",
             words_sent, NUM_PHASES + 2);
    $display("%0d results checked, %0d of them fire pulses", results_seen, fires_seen);
    if (outstanding != 0) $display("%0d results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/mdet_pkg.sv
sv/mdet_front.sv
sv/mdet_fifo.sv
sv/mdet_div.sv
sv/mdet_back.sv
sv/ms_delay_event_timer.sv
sv/mdet_checker.sv
sim/mdet_timer_check.sv
sim/ms_delay_event_timer_test.sv
